@@ hdl/mfhp_pkg.sv @@
// Shared types, constants and header position helpers of the mesh frame header parser.
`timescale 1ns / 1ps

package mfhp_pkg;

  // Widths
  localparam int unsigned FrameLenW = 8;   // frame length in bytes, limit at most 255
  localparam int unsigned PosW      = 10;  // byte positions past the relay list
  localparam int unsigned PayW      = 7;   // payload offset and length fields

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_SHORT  = 3'd1,
    ST_MAC_REJECT = 3'd2,
    ST_NWK_REJECT = 3'd3,
    ST_APS_REJECT = 3'd4,
    ST_MISMATCH   = 3'd5,
    ST_TOO_LONG   = 3'd6
  } mfhp_status_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_WANTED_PROFILE  = 1'b0,
    CFG_WANTED_ENDPOINT = 1'b1
  } mfhp_cfg_idx_e;

  localparam logic [15:0] WANTED_PROFILE_RST  = 16'h0f05;
  localparam logic [7:0]  WANTED_ENDPOINT_RST = 8'h14;

  // Fixed MAC header byte positions
  localparam logic [PosW-1:0] POS_MAC_CTL_LO = 10'd0;
  localparam logic [PosW-1:0] POS_MAC_CTL_HI = 10'd1;
  localparam logic [PosW-1:0] POS_PAN_LO     = 10'd3;
  localparam logic [PosW-1:0] POS_PAN_HI     = 10'd4;

  // Network header start with and without PAN ID compression
  localparam logic [PosW-1:0] NWK_POS_COMPRESSED = 10'd9;
  localparam logic [PosW-1:0] NWK_POS_FULL       = 10'd11;

  localparam logic [PosW-1:0] MIN_FRAME_BYTES = 10'd9;
  localparam logic [PosW-1:0] NWK_HDR_BYTES   = 10'd8;
  localparam logic [PosW-1:0] IEEE_ADDR_BYTES = 10'd8;
  localparam logic [PosW-1:0] RELAY_HDR_BYTES = 10'd2;
  localparam logic [PosW-1:0] APS_HDR_BYTES   = 10'd8;

  // MAC frame control
  localparam int unsigned MAC_PANCOMP_BIT = 6;
  localparam logic [2:0]  MAC_TYPE_DATA   = 3'd1;
  localparam logic [1:0]  MAC_ADDR_SHORT  = 2'd2;
  localparam logic [15:0] MAC_RSVD_MASK   = 16'h0308;
  localparam logic [15:0] MAC_VER_MASK    = 16'h3000;

  // Network frame control
  localparam int unsigned NWK_SRC_ROUTE_BIT = 10;
  localparam int unsigned NWK_DST_IEEE_BIT  = 11;
  localparam int unsigned NWK_SRC_IEEE_BIT  = 12;
  localparam logic [15:0] NWK_SEC_MASK      = 16'h0200;
  localparam logic [3:0]  NWK_VERSION       = 4'd2;
  localparam logic [1:0]  NWK_TYPE_DATA     = 2'd0;
  localparam logic [1:0]  NWK_TYPE_CMD      = 2'd1;

  // APS frame control
  localparam logic [1:0] APS_TYPE_DATA  = 2'd0;
  localparam logic [7:0] APS_BAD_MASK   = 8'he0;
  localparam logic [7:0] APS_DELIV_MASK = 8'h0c;

  // Header words captured from one frame
  typedef struct packed {
    logic [15:0] mac_ctl;
    logic [15:0] pan;
    logic [15:0] nwk_ctl;
    logic [15:0] dst;
    logic [15:0] src;
    logic [7:0]  nwk_seq;
    logic [7:0]  relay_cnt;
    logic [7:0]  aps_ctl;
    logic [7:0]  endpoint;
    logic [15:0] cluster;
    logic [15:0] profile;
    logic [7:0]  aps_seq;
  } mfhp_hdr_t;

  // One finished frame handed to the checker
  typedef struct packed {
    logic                 ovf;
    logic [FrameLenW-1:0] frame_len;
    mfhp_hdr_t            hdr;
  } mfhp_rec_t;

  // One result item
  typedef struct packed {
    logic            accepted;
    mfhp_status_e    status;
    logic            network_command;
    logic [15:0]     pan_id;
    logic [15:0]     dst_addr;
    logic [15:0]     src_addr;
    logic [7:0]      seq_number;
    logic [7:0]      dest_endpoint;
    logic [15:0]     cluster_id;
    logic [15:0]     profile_id;
    logic [PayW-1:0] payload_offset;
    logic [PayW-1:0] payload_length;
  } mfhp_res_t;

  function automatic logic [PosW-1:0] mfhp_nwk_pos(input logic [15:0] mac_ctl);
    return mac_ctl[MAC_PANCOMP_BIT] ? NWK_POS_COMPRESSED : NWK_POS_FULL;
  endfunction

  // Position of the relay count byte (first byte past the optional IEEE addresses)
  function automatic logic [PosW-1:0] mfhp_rly_pos(input logic [PosW-1:0] nwk_pos,
                                                  input logic [15:0] nwk_ctl);
    logic [PosW-1:0] dst_ext;
    logic [PosW-1:0] src_ext;
    dst_ext = nwk_ctl[NWK_DST_IEEE_BIT] ? IEEE_ADDR_BYTES : '0;
    src_ext = nwk_ctl[NWK_SRC_IEEE_BIT] ? IEEE_ADDR_BYTES : '0;
    return nwk_pos + NWK_HDR_BYTES + dst_ext + src_ext;
  endfunction

  // Start of the APS header: past the relay list when source routing is on
  function automatic logic [PosW-1:0] mfhp_aps_pos(input logic [PosW-1:0] rly_pos,
                                                  input logic [15:0] nwk_ctl,
                                                  input logic [7:0] relay_cnt);
    logic [PosW-1:0] list_bytes;
    list_bytes = PosW'({relay_cnt, 1'b0});
    return nwk_ctl[NWK_SRC_ROUTE_BIT] ? rly_pos + RELAY_HDR_BYTES + list_bytes : rly_pos;
  endfunction

endpackage

@@ hdl/mfhp_capture.sv @@
// Byte position tracking and header field capture, one frame record per final byte.
`timescale 1ns / 1ps

module mfhp_capture #(
  parameter int unsigned MAX_FRAME_BYTES = 127
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              frame_last_i,
  output logic              rec_valid_o,
  input  logic              rec_ready_i,
  output mfhp_pkg::mfhp_rec_t rec_o
);
  import mfhp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_FRAME_BYTES);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            rec_valid_q, rec_valid_d;
  mfhp_hdr_t       hdr_q, hdr_d;
  mfhp_rec_t       rec_q;
  logic            fire;
  logic            full;
  logic [PosW-1:0] pos;
  logic [PosW-1:0] nwk_pos;
  logic [PosW-1:0] rly_pos;
  logic [PosW-1:0] aps_pos;
  logic [PosW-1:0] rel_nwk;
  logic [PosW-1:0] rel_aps;

  assign in_ready_o  = !rec_valid_q || rec_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign full        = (cnt_q == MaxCnt);
  assign rec_valid_o = rec_valid_q;
  assign rec_o       = rec_q;

  // Section positions come from header words of this frame seen at lower positions
  assign pos     = PosW'(cnt_q);
  assign nwk_pos = mfhp_nwk_pos(hdr_q.mac_ctl);
  assign rly_pos = mfhp_rly_pos(nwk_pos, hdr_q.nwk_ctl);
  assign aps_pos = mfhp_aps_pos(rly_pos, hdr_q.nwk_ctl, hdr_q.relay_cnt);
  assign rel_nwk = pos - nwk_pos;
  assign rel_aps = pos - aps_pos;

  always_comb begin
    hdr_d = hdr_q;
    if (fire && !full) begin
      case (pos)
        POS_MAC_CTL_LO: hdr_d.mac_ctl[7:0]  = rx_byte_i;
        POS_MAC_CTL_HI: hdr_d.mac_ctl[15:8] = rx_byte_i;
        POS_PAN_LO:     hdr_d.pan[7:0]      = rx_byte_i;
        POS_PAN_HI:     hdr_d.pan[15:8]     = rx_byte_i;
        default: ;
      endcase
      if (rel_nwk < NWK_HDR_BYTES) begin
        case (rel_nwk[2:0])
          3'd0:    hdr_d.nwk_ctl[7:0]  = rx_byte_i;
          3'd1:    hdr_d.nwk_ctl[15:8] = rx_byte_i;
          3'd2:    hdr_d.dst[7:0]      = rx_byte_i;
          3'd3:    hdr_d.dst[15:8]     = rx_byte_i;
          3'd4:    hdr_d.src[7:0]      = rx_byte_i;
          3'd5:    hdr_d.src[15:8]     = rx_byte_i;
          3'd7:    hdr_d.nwk_seq       = rx_byte_i;
          default: ;  // radius byte is not kept
        endcase
      end
      if (pos == rly_pos) begin
        hdr_d.relay_cnt = rx_byte_i;
      end
      if (rel_aps < APS_HDR_BYTES) begin
        case (rel_aps[2:0])
          3'd0:    hdr_d.aps_ctl        = rx_byte_i;
          3'd1:    hdr_d.endpoint       = rx_byte_i;
          3'd2:    hdr_d.cluster[7:0]   = rx_byte_i;
          3'd3:    hdr_d.cluster[15:8]  = rx_byte_i;
          3'd4:    hdr_d.profile[7:0]   = rx_byte_i;
          3'd5:    hdr_d.profile[15:8]  = rx_byte_i;
          3'd7:    hdr_d.aps_seq        = rx_byte_i;
          default: ;  // source endpoint is not kept
        endcase
      end
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    rec_valid_d = rec_valid_q;
    if (rec_valid_q && rec_ready_i) begin
      rec_valid_d = 1'b0;
    end
    if (fire) begin
      if (frame_last_i) begin
        cnt_d       = '0;
        ovf_d       = 1'b0;
        rec_valid_d = 1'b1;
      end else if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rec_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      ovf_q       <= ovf_d;
      rec_valid_q <= rec_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_d;
    if (fire && frame_last_i) begin
      rec_q.hdr       <= hdr_d;
      rec_q.ovf       <= ovf_q || full;
      rec_q.frame_len <= FrameLenW'(cnt_q) + FrameLenW'(1);
    end
  end

endmodule

@@ hdl/mfhp_check.sv @@
// Header checks and result field selection for one buffered frame record.
`timescale 1ns / 1ps

module mfhp_check (
  input  mfhp_pkg::mfhp_rec_t rec_i,
  input  logic [15:0]         wanted_profile_i,
  input  logic [7:0]          wanted_endpoint_i,
  output mfhp_pkg::mfhp_res_t res_o
);
  import mfhp_pkg::*;

  logic [PosW-1:0] len;
  logic [PosW-1:0] nwk_pos;
  logic [PosW-1:0] rly_pos;
  logic [PosW-1:0] aps_pos;
  logic [PosW-1:0] aps_end;
  logic [PosW-1:0] cmd_pay_len;
  logic [PosW-1:0] data_pay_len;
  logic            mac_ok;
  logic            nwk_ok;
  logic            aps_ok;
  logic            match;
  logic [1:0]      nwk_type;

  assign len      = PosW'(rec_i.frame_len);
  assign nwk_pos  = mfhp_nwk_pos(rec_i.hdr.mac_ctl);
  assign rly_pos  = mfhp_rly_pos(nwk_pos, rec_i.hdr.nwk_ctl);
  assign aps_pos  = mfhp_aps_pos(rly_pos, rec_i.hdr.nwk_ctl, rec_i.hdr.relay_cnt);
  assign aps_end  = aps_pos + APS_HDR_BYTES;
  assign nwk_type = rec_i.hdr.nwk_ctl[1:0];

  assign cmd_pay_len  = len - aps_pos;
  assign data_pay_len = len - aps_end;

  assign mac_ok = (rec_i.hdr.mac_ctl[2:0] == MAC_TYPE_DATA)
               && ((rec_i.hdr.mac_ctl & MAC_RSVD_MASK) == '0)
               && (rec_i.hdr.mac_ctl[11:10] == MAC_ADDR_SHORT)
               && (rec_i.hdr.mac_ctl[15:14] == MAC_ADDR_SHORT)
               && ((rec_i.hdr.mac_ctl & MAC_VER_MASK) == '0);

  assign nwk_ok = ((rec_i.hdr.nwk_ctl & NWK_SEC_MASK) == '0)
               && (rec_i.hdr.nwk_ctl[5:2] == NWK_VERSION);

  assign aps_ok = (rec_i.hdr.aps_ctl[1:0] == APS_TYPE_DATA)
               && ((rec_i.hdr.aps_ctl & APS_BAD_MASK) == '0)
               && ((rec_i.hdr.aps_ctl & APS_DELIV_MASK) != APS_DELIV_MASK);

  assign match = (rec_i.hdr.profile == wanted_profile_i)
              && (rec_i.hdr.endpoint == wanted_endpoint_i);

  // Fields of a header stage that was never reached stay zero
  always_comb begin
    res_o        = '0;
    res_o.status = ST_OK;
    if (rec_i.ovf) begin
      res_o.status = ST_TOO_LONG;
    end else if (len < MIN_FRAME_BYTES) begin
      res_o.status = ST_TOO_SHORT;
    end else if (!mac_ok) begin
      res_o.status = ST_MAC_REJECT;
    end else begin
      res_o.pan_id = rec_i.hdr.pan;
      if (len < nwk_pos + NWK_HDR_BYTES) begin
        res_o.status = ST_TOO_SHORT;
      end else if (!nwk_ok) begin
        res_o.status = ST_NWK_REJECT;
      end else begin
        res_o.dst_addr   = rec_i.hdr.dst;
        res_o.src_addr   = rec_i.hdr.src;
        res_o.seq_number = rec_i.hdr.nwk_seq;
        if (rec_i.hdr.nwk_ctl[NWK_SRC_ROUTE_BIT] && (rly_pos + RELAY_HDR_BYTES > len)) begin
          res_o.status = ST_TOO_SHORT;
        end else if (aps_pos > len) begin
          res_o.status = ST_TOO_SHORT;
        end else if (nwk_type == NWK_TYPE_CMD) begin
          res_o.network_command = 1'b1;
          res_o.payload_offset  = aps_pos[PayW-1:0];
          res_o.payload_length  = cmd_pay_len[PayW-1:0];
          res_o.status          = ST_OK;
        end else if (nwk_type != NWK_TYPE_DATA) begin
          res_o.status = ST_NWK_REJECT;
        end else if (aps_end > len) begin
          res_o.status = ST_TOO_SHORT;
        end else if (!aps_ok) begin
          res_o.status = ST_APS_REJECT;
        end else begin
          res_o.dest_endpoint  = rec_i.hdr.endpoint;
          res_o.cluster_id     = rec_i.hdr.cluster;
          res_o.profile_id     = rec_i.hdr.profile;
          res_o.seq_number     = rec_i.hdr.aps_seq;
          res_o.payload_offset = aps_end[PayW-1:0];
          res_o.payload_length = data_pay_len[PayW-1:0];
          res_o.status         = match ? ST_OK : ST_MISMATCH;
        end
      end
    end
    res_o.accepted = (res_o.status == ST_OK);
  end

endmodule

@@ hdl/mesh_frame_header_parser_unit.sv @@
// Mesh frame header parser top: configuration, capture, checker and result register.
`timescale 1ns / 1ps

// Mesh frame header parser (802.15.4 MAC, mesh network and APS headers).
// Input channel: one frame byte per transfer (rx_byte_i, frame_last_i) under
//   in_valid_i / in_ready_o. The byte after a final byte starts a new frame.
// Output channel: one result per frame under out_valid_o / out_ready_i,
//   holding status, acceptance and the captured header fields.
// Throughput: one byte per cycle while in_ready_o is high. Header fields are
//   captured as their byte positions go by, so no frame buffer is kept; the
//   only per-frame work is the final check, which runs between the frame
//   record register and the result register.
// Result path: the final byte's transfer loads the frame record register;
//   the result register takes the record once it is empty or its result is taken.
// Stall: while a result waits, the frame record can hold one more finished
//   frame; bytes keep flowing until a final byte fills the record, then
//   in_ready_o stays low until the receiver takes a transfer.
// Reset: byte position, overflow flag and both valid flags clear at once,
//   wanted_profile returns to 0x0F05 and wanted_endpoint to 0x14. No
//   clearing pass is needed; the block takes bytes in the first cycle.
// Configuration: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is
//   high (0 wanted profile, 1 wanted endpoint); write only while idle.
module mesh_frame_header_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [2:0]  status_o,
  output logic        network_command_o,
  output logic [15:0] pan_id_o,
  output logic [15:0] dst_addr_o,
  output logic [15:0] src_addr_o,
  output logic [7:0]  seq_number_o,
  output logic [7:0]  dest_endpoint_o,
  output logic [15:0] cluster_id_o,
  output logic [15:0] profile_id_o,
  output logic [6:0]  payload_offset_o,
  output logic [6:0]  payload_length_o
);
  import mfhp_pkg::*;

  logic [15:0] wanted_profile_q;
  logic [7:0]  wanted_endpoint_q;
  logic        rec_valid;
  logic        rec_ready;
  mfhp_rec_t   rec;
  mfhp_res_t   res;
  mfhp_res_t   res_q;
  logic        out_valid_q, out_valid_d;

  // Configuration registers; an unknown index is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_profile_q  <= WANTED_PROFILE_RST;
      wanted_endpoint_q <= WANTED_ENDPOINT_RST;
    end else if (cfg_we_i) begin
      case (mfhp_cfg_idx_e'(cfg_idx_i))
        CFG_WANTED_PROFILE:  wanted_profile_q  <= cfg_wdata_i;
        CFG_WANTED_ENDPOINT: wanted_endpoint_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Track byte positions and hand a record over on each final byte
  mfhp_capture #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .frame_last_i (frame_last_i),
    .rec_valid_o  (rec_valid),
    .rec_ready_i  (rec_ready),
    .rec_o        (rec)
  );

  // Check the record against the header rules and the wanted profile/endpoint
  mfhp_check u_check (
    .rec_i             (rec),
    .wanted_profile_i  (wanted_profile_q),
    .wanted_endpoint_i (wanted_endpoint_q),
    .res_o             (res)
  );

  // Result register: advance when empty or when the receiver takes the transfer
  assign rec_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (rec_valid && rec_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_valid && rec_ready) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = res_q.accepted;
  assign status_o          = res_q.status;
  assign network_command_o = res_q.network_command;
  assign pan_id_o          = res_q.pan_id;
  assign dst_addr_o        = res_q.dst_addr;
  assign src_addr_o        = res_q.src_addr;
  assign seq_number_o      = res_q.seq_number;
  assign dest_endpoint_o   = res_q.dest_endpoint;
  assign cluster_id_o      = res_q.cluster_id;
  assign profile_id_o      = res_q.profile_id;
  assign payload_offset_o  = res_q.payload_offset;
  assign payload_length_o  = res_q.payload_length;

`ifndef SYNTHESIS
  // Acceptance and status agree on every result
  a_accept_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (status_o == ST_OK)))
    else $error("accepted does not match status");

  // An over-long frame reports nothing but its status
  a_too_long_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_TOO_LONG)) |->
      (pan_id_o == '0 && dst_addr_o == '0 && profile_id_o == '0 &&
       payload_length_o == '0 && !network_command_o))
    else $error("too long frame carries header fields");

  // A network command is accepted as soon as its header fits
  a_cmd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && network_command_o) |-> (status_o == ST_OK && profile_id_o == '0))
    else $error("network command frame not accepted");

  // A mismatch really differs from the configured profile or endpoint
  a_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_MISMATCH)) |->
      (profile_id_o != wanted_profile_q || dest_endpoint_o != wanted_endpoint_q))
    else $error("mismatch reported for matching frame");

  // A waiting frame record is taken whenever the result register frees up
  a_record_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_valid && !out_valid_q) |=> out_valid_q)
    else $error("frame record not moved to empty result register");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the mesh frame header parser: table-driven and random frames.
`timescale 1ns / 1ps

module testbench;
  import mfhp_pkg::*;

  localparam int unsigned FRAME_LIMIT = 127;  // block's MAX_FRAME_BYTES default
  localparam int unsigned PHASE_BYTES = 160;  // random bytes per register setting
  localparam int unsigned DRAIN_CYCLES = 4;   // settle wait after the outstanding results are taken

  typedef logic [7:0] octets_t[$];

  // One frame to build: header control words and the shape of the frame.
  // frame_len: 0 keeps the natural length, >0 cuts or pads to it, <0 cuts at random.
  typedef struct {
    logic [15:0]  mac_ctl;
    logic [15:0]  nwk_ctl;
    logic [7:0]   relay_cnt;
    logic [7:0]   aps_ctl;
    logic [7:0]   endpoint;
    logic [15:0]  profile;
    int           pay_len;
    int           frame_len;
    bit           typed;
    mfhp_status_e typed_st;
  } frame_spec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_idx = CFG_WANTED_PROFILE;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic        frame_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic [2:0]  status;
  logic        network_command;
  logic [15:0] pan_id;
  logic [15:0] dst_addr;
  logic [15:0] src_addr;
  logic [7:0]  seq_number;
  logic [7:0]  dest_endpoint;
  logic [15:0] cluster_id;
  logic [15:0] profile_id;
  logic [6:0]  payload_offset;
  logic [6:0]  payload_length;

  // Bench copy of the filter registers
  logic [15:0] want_profile = WANTED_PROFILE_RST;
  logic [7:0]  want_endpoint = WANTED_ENDPOINT_RST;

  mfhp_res_t   frame_verdicts[$];  // expected result of each frame already sent
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned hold_left = 0;
  bit          rx_steady = 1'b0;
  frame_spec_t directed_frames [0:25];

  mesh_frame_header_parser_unit u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .rx_byte_i         (rx_byte),
    .frame_last_i      (frame_last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .accepted_o        (accepted),
    .status_o          (status),
    .network_command_o (network_command),
    .pan_id_o          (pan_id),
    .dst_addr_o        (dst_addr),
    .src_addr_o        (src_addr),
    .seq_number_o      (seq_number),
    .dest_endpoint_o   (dest_endpoint),
    .cluster_id_o      (cluster_id),
    .profile_id_o      (profile_id),
    .payload_offset_o  (payload_offset),
    .payload_length_o  (payload_length)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs on either channel
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle length for either side: mostly none, often short, now and then long
  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Work out the result of one whole frame, header stage by header stage.
  // Fields of a stage not reached stay zero; accepted is set by the caller.
  function automatic mfhp_res_t decode_frame(input octets_t fb);
    mfhp_res_t   r;
    int unsigned n;
    int unsigned k;
    logic [15:0] mac_ctl;
    logic [15:0] nwk_ctl;
    logic [7:0]  aps_ctl;
    r = '0;
    n = fb.size();
    if (n > FRAME_LIMIT) begin
      r.status = ST_TOO_LONG;
      return r;
    end
    if (n < 9) begin
      r.status = ST_TOO_SHORT;
      return r;
    end
    mac_ctl = {fb[1], fb[0]};
    if (mac_ctl[2:0] != MAC_TYPE_DATA || (mac_ctl & MAC_RSVD_MASK) != '0 ||
        mac_ctl[11:10] != MAC_ADDR_SHORT || mac_ctl[15:14] != MAC_ADDR_SHORT ||
        (mac_ctl & MAC_VER_MASK) != '0) begin
      r.status = ST_MAC_REJECT;
      return r;
    end
    r.pan_id = {fb[4], fb[3]};
    // Network header follows the source address; no source PAN when compressed
    k = mac_ctl[MAC_PANCOMP_BIT] ? 9 : 11;
    if (n < k + 8) begin
      r.status = ST_TOO_SHORT;
      return r;
    end
    nwk_ctl = {fb[k+1], fb[k]};
    if ((nwk_ctl & NWK_SEC_MASK) != '0 || nwk_ctl[5:2] != NWK_VERSION) begin
      r.status = ST_NWK_REJECT;
      return r;
    end
    r.dst_addr   = {fb[k+3], fb[k+2]};
    r.src_addr   = {fb[k+5], fb[k+4]};
    r.seq_number = fb[k+7];
    k += 8;
    if (nwk_ctl[NWK_DST_IEEE_BIT]) k += 8;
    if (nwk_ctl[NWK_SRC_IEEE_BIT]) k += 8;
    if (nwk_ctl[NWK_SRC_ROUTE_BIT]) begin
      if (k + 2 > n) begin
        r.status = ST_TOO_SHORT;
        return r;
      end
      k += 2 + 2 * fb[k];
    end
    if (k > n) begin
      r.status = ST_TOO_SHORT;
      return r;
    end
    if (nwk_ctl[1:0] == NWK_TYPE_CMD) begin
      r.network_command = 1'b1;
      r.payload_offset  = PayW'(k);
      r.payload_length  = PayW'(n - k);
      r.status          = ST_OK;
      return r;
    end
    // Reserved network types are rejected before the APS length is looked at
    if (nwk_ctl[1:0] != NWK_TYPE_DATA) begin
      r.status = ST_NWK_REJECT;
      return r;
    end
    if (k + 8 > n) begin
      r.status = ST_TOO_SHORT;
      return r;
    end
    aps_ctl = fb[k];
    if (aps_ctl[1:0] != APS_TYPE_DATA || (aps_ctl & APS_BAD_MASK) != '0 ||
        (aps_ctl & APS_DELIV_MASK) == APS_DELIV_MASK) begin
      r.status = ST_APS_REJECT;
      return r;
    end
    r.dest_endpoint  = fb[k+1];
    r.cluster_id     = {fb[k+3], fb[k+2]};
    r.profile_id     = {fb[k+5], fb[k+4]};
    r.seq_number     = fb[k+7];
    r.payload_offset = PayW'(k + 8);
    r.payload_length = PayW'(n - k - 8);
    if (r.profile_id == want_profile && r.dest_endpoint == want_endpoint)
      r.status = ST_OK;
    else
      r.status = ST_MISMATCH;
    return r;
  endfunction

  // Lay out the frame bytes; addresses, sequences and payload are random
  function automatic octets_t build_frame(input frame_spec_t s);
    octets_t fb;
    int      target;
    fb.push_back(s.mac_ctl[7:0]);
    fb.push_back(s.mac_ctl[15:8]);
    // sequence, destination PAN and address, source PAN unless compressed, source address
    repeat (s.mac_ctl[MAC_PANCOMP_BIT] ? 7 : 9) fb.push_back(8'($urandom));
    fb.push_back(s.nwk_ctl[7:0]);
    fb.push_back(s.nwk_ctl[15:8]);
    repeat (6) fb.push_back(8'($urandom));
    if (s.nwk_ctl[NWK_DST_IEEE_BIT]) repeat (8) fb.push_back(8'($urandom));
    if (s.nwk_ctl[NWK_SRC_IEEE_BIT]) repeat (8) fb.push_back(8'($urandom));
    if (s.nwk_ctl[NWK_SRC_ROUTE_BIT]) begin
      fb.push_back(s.relay_cnt);
      repeat (1 + 2 * int'(s.relay_cnt)) fb.push_back(8'($urandom));
    end
    if (s.nwk_ctl[1:0] != NWK_TYPE_CMD) begin
      fb.push_back(s.aps_ctl);
      fb.push_back(s.endpoint);
      repeat (2) fb.push_back(8'($urandom));
      fb.push_back(s.profile[7:0]);
      fb.push_back(s.profile[15:8]);
      repeat (2) fb.push_back(8'($urandom));
    end
    repeat (s.pay_len) fb.push_back(8'($urandom));
    if (s.frame_len > 0) target = s.frame_len;
    else if (s.frame_len < 0) target = $urandom_range(1, fb.size() - 1);
    else target = fb.size();
    while (fb.size() > target) void'(fb.pop_back());
    while (fb.size() < target) fb.push_back(8'($urandom));
    return fb;
  endfunction

  // Mostly well-formed frames with random content, the rest broken or noise
  function automatic frame_spec_t rand_spec();
    frame_spec_t s;
    int unsigned pick;
    s.mac_ctl   = 16'h8801 | (16'($urandom) & 16'h00F0);
    s.nwk_ctl   = 16'h0008 | (16'($urandom) & 16'hFDC0);
    s.relay_cnt = 8'($urandom_range(0, 4));
    s.aps_ctl   = 8'($urandom_range(0, 2) << 2) | (8'($urandom) & 8'h10);
    s.endpoint  = ($urandom_range(0, 4) != 0) ? want_endpoint : 8'($urandom);
    s.profile   = ($urandom_range(0, 4) != 0) ? want_profile : 16'($urandom);
    s.pay_len   = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
    s.frame_len = 0;
    s.typed     = 1'b0;
    s.typed_st  = ST_OK;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      // keep the well-formed data frame
    end else if (pick < 65) begin
      s.nwk_ctl[1:0] = NWK_TYPE_CMD;
    end else if (pick < 70) begin
      s.nwk_ctl[1:0] = 2'($urandom_range(2, 3));
    end else if (pick < 80) begin
      // flip one control bit in one of the three headers
      case ($urandom_range(0, 2))
        0:       s.mac_ctl ^= 16'd1 << $urandom_range(0, 15);
        1:       s.nwk_ctl ^= 16'd1 << $urandom_range(0, 15);
        default: s.aps_ctl ^= 8'd1 << $urandom_range(0, 7);
      endcase
    end else if (pick < 88) begin
      s.frame_len = -1;
    end else if (pick < 93) begin
      s.mac_ctl   = 16'($urandom);
      s.nwk_ctl   = 16'($urandom);
      s.relay_cnt = 8'($urandom);
      s.aps_ctl   = 8'($urandom);
      s.frame_len = $urandom_range(1, 40);
    end else if (pick < 97) begin
      s.relay_cnt = 8'($urandom_range(5, 40));
      s.nwk_ctl[NWK_SRC_ROUTE_BIT] = 1'b1;
    end else begin
      s.frame_len = $urandom_range(FRAME_LIMIT + 1, FRAME_LIMIT + 23);
    end
    return s;
  endfunction

  // Offer one byte, idle first if the gap says so, and hold until the transfer
  task automatic put_byte(input logic [7:0] b, input logic last, input bit steady);
    int unsigned gap;
    gap = steady ? 0 : idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    rx_byte    <= b;
    frame_last <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Send a frame and queue its expected result once its last byte is taken
  task automatic send_frame(input octets_t fb, input bit typed, input mfhp_status_e typed_st);
    mfhp_res_t verdict;
    bit        steady;
    steady = ($urandom_range(0, 4) == 0);
    foreach (fb[i]) put_byte(fb[i], i == fb.size() - 1, steady);
    verdict = decode_frame(fb);
    if (typed) begin
      verdict        = '0;
      verdict.status = typed_st;
    end
    verdict.accepted = (verdict.status == ST_OK);
    frame_verdicts.push_back(verdict);
    bytes_sent += fb.size();
  endtask

  // Drop valid and wait for every result, then let the pipeline settle
  task automatic drain(input int unsigned settle);
    in_valid <= 1'b0;
    while (frame_verdicts.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write both filter registers on back-to-back edges
  task automatic set_filter(input logic [15:0] prof, input logic [7:0] ep);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_WANTED_PROFILE;
    cfg_wdata <= prof;
    @(posedge clk);
    cfg_idx   <= CFG_WANTED_ENDPOINT;
    cfg_wdata <= {8'($urandom), ep};  // upper byte must be ignored
    @(posedge clk);
    cfg_we <= 1'b0;
    want_profile  = prof;
    want_endpoint = ep;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Receiver: stall at random, with occasional stretches of steady ready
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
    if (hold_left != 0) hold_left--;
    else hold_left = rx_steady ? 0 : idle_gap();
    out_ready <= (hold_left == 0);
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk) begin : check_results
    mfhp_res_t want;
    if (out_valid && out_ready) begin
      if (frame_verdicts.size() == 0) begin
        report_mismatch("result transfer with no frame outstanding");
      end else begin
        want = frame_verdicts.pop_front();
        check_field("accepted", 16'(accepted), 16'(want.accepted));
        check_field("status", 16'(status), 16'(want.status));
        check_field("network_command", 16'(network_command), 16'(want.network_command));
        check_field("pan_id", pan_id, want.pan_id);
        check_field("dst_addr", dst_addr, want.dst_addr);
        check_field("src_addr", src_addr, want.src_addr);
        check_field("seq_number", 16'(seq_number), 16'(want.seq_number));
        check_field("dest_endpoint", 16'(dest_endpoint), 16'(want.dest_endpoint));
        check_field("cluster_id", cluster_id, want.cluster_id);
        check_field("profile_id", profile_id, want.profile_id);
        check_field("payload_offset", 16'(payload_offset), 16'(want.payload_offset));
        check_field("payload_length", 16'(payload_length), 16'(want.payload_length));
      end
    end
  end

  initial begin : stimulus
    int unsigned ph;
    logic [15:0] prof;
    logic [7:0]  ep;
    // Directed frames, sent with the reset values of the filter registers.
    // Typed rows carry a result with every field zero but the status.
    directed_frames = '{
      // plain data frame that matches the reset filter
      '{16'h8841, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b0, ST_OK},
      // single byte frame and a frame one byte short of the MAC minimum
      '{16'h8841, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 1, 1'b1, ST_TOO_SHORT},
      '{16'h8801, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 8, 1'b1, ST_TOO_SHORT},
      // MAC rejects: frame type, security, reserved bit, version, address modes
      '{16'h8842, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b1, ST_MAC_REJECT},
      '{16'h8849, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b1, ST_MAC_REJECT},
      '{16'h8941, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b1, ST_MAC_REJECT},
      '{16'h9841, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b1, ST_MAC_REJECT},
      '{16'hC841, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b1, ST_MAC_REJECT},
      '{16'h8441, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b1, ST_MAC_REJECT},
      // network header cut short, then network security, version, reserved type
      '{16'h8841, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 16, 1'b0, ST_OK},
      '{16'h8801, 16'h0208, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b0, ST_OK},
      '{16'h8841, 16'h000C, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b0, ST_OK},
      '{16'h8841, 16'h000A, 8'd0, 8'h00, 8'h14, 16'h0F05, 4, 0, 1'b0, ST_OK},
      // network commands, with and without payload
      '{16'h8801, 16'h0009, 8'd0, 8'h00, 8'h14, 16'h0F05, 3, 0, 1'b0, ST_OK},
      '{16'h8841, 16'h1C09, 8'd2, 8'h00, 8'h14, 16'h0F05, 0, 0, 1'b0, ST_OK},
      // every ignored control bit set, both IEEE addresses and a relay list
      '{16'h88F1, 16'hFDC8, 8'd2, 8'h18, 8'h14, 16'h0F05, 6, 0, 1'b0, ST_OK},
      // relay list running past the end of the frame
      '{16'h8841, 16'h0408, 8'd200, 8'h00, 8'h14, 16'h0F05, 0, 40, 1'b0, ST_OK},
      // APS rejects: frame type, high control bits, reserved delivery mode
      '{16'h8841, 16'h0008, 8'd0, 8'h01, 8'h14, 16'h0F05, 4, 0, 1'b0, ST_OK},
      '{16'h8841, 16'h0008, 8'd0, 8'h20, 8'h14, 16'h0F05, 4, 0, 1'b0, ST_OK},
      '{16'h8841, 16'h0008, 8'd0, 8'h0C, 8'h14, 16'h0F05, 4, 0, 1'b0, ST_OK},
      // profile mismatch and endpoint mismatch
      '{16'h8841, 16'h0008, 8'd0, 8'h08, 8'h14, 16'h0F04, 4, 0, 1'b0, ST_OK},
      '{16'h8841, 16'h0008, 8'd0, 8'h00, 8'h15, 16'h0F05, 4, 0, 1'b0, ST_OK},
      // longest legal frame, one byte over, and a long frame of extreme controls
      '{16'h8841, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 0, 127, 1'b0, ST_OK},
      '{16'h8841, 16'h0008, 8'd0, 8'h00, 8'h14, 16'h0F05, 0, 128, 1'b1, ST_TOO_LONG},
      '{16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 0, 200, 1'b1, ST_TOO_LONG},
      // all-zero controls at the MAC minimum length
      '{16'h0000, 16'h0000, 8'd0, 8'h00, 8'h00, 16'h0000, 0, 9, 1'b1, ST_MAC_REJECT}
    };

    // Hold reset, then release it on a clock edge
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_frames[i])
      send_frame(build_frame(directed_frames[i]), directed_frames[i].typed,
                 directed_frames[i].typed_st);

    // Random frames under several filter settings, extremes included
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          prof = 16'h0000;
          ep   = 8'h00;
        end
        1: begin
          prof = 16'hFFFF;
          ep   = 8'hFF;
        end
        4: begin
          prof = WANTED_PROFILE_RST;
          ep   = WANTED_ENDPOINT_RST;
        end
        default: begin
          prof = 16'($urandom);
          ep   = 8'($urandom);
        end
      endcase
      drain(DRAIN_CYCLES);
      set_filter(prof, ep);
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) send_frame(build_frame(rand_spec()), 1'b0, ST_OK);
    end

    // Wait out the last results and watch for stray transfers
    drain(4 * DRAIN_CYCLES);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
